### rtl/tppid_pkg.sv
// Package for the three-axis position PID controller.
// Holds widths, scaling constants, register indexes and shared types.
// No dependencies.
package tppid_pkg;

  localparam int POS_WIDTH_DEF      = 16;
  localparam int INTEGRAL_WIDTH_DEF = 32;

  localparam int RAW_W    = 16;
  localparam int SP_W     = 16;
  localparam int ERR_W    = 17;
  localparam int CMD_W    = 11;
  localparam int GAIN_W   = 48;
  localparam int COEF_W   = 16;
  localparam int IDX_W    = 3;
  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam int MUL_A_W = 29;
  localparam int SUM_W   = 62;

  localparam int Z_OFFSET = 8192;
  localparam int KP_SCALE = 150;
  localparam int KD_SCALE = 2500;
  localparam int KI_SCALE = 9;
  localparam int DIV_SCALE = 38400;

  localparam int RECIP       = 111849;
  localparam int RECIP_SHIFT = 23;
  localparam int DIV_SHIFT   = 9;
  localparam int SCALED_W    = 16;
  localparam int QUOT_W      = 10;
  localparam int SAT_LIMIT   = 501 * DIV_SCALE;

  localparam int ITERM_W = 61;
  localparam logic [63:0] KI_LIMIT     = 64'd1 << 60;
  localparam logic [63:0] KI_LIMIT_PRE = KI_LIMIT / KI_SCALE;

  localparam int CMD_MID     = 1500;
  localparam int CMD_MAX     = 2000;
  localparam int CMD_MIN_RP  = 1000;
  localparam int CMD_MIN_THR = 1500;

  localparam logic signed [SP_W-1:0] SETPOINT_X_RST = 16'sd26;
  localparam logic signed [SP_W-1:0] SETPOINT_Y_RST = 16'sd0;
  localparam logic signed [SP_W-1:0] SETPOINT_Z_RST = 16'sd4864;

  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT_X     = 3'd0,
    REG_SETPOINT_Y     = 3'd1,
    REG_SETPOINT_Z     = 3'd2,
    REG_GAINS_ROLL     = 3'd3,
    REG_GAINS_PITCH    = 3'd4,
    REG_GAINS_THROTTLE = 3'd5
  } reg_index_t;

  typedef enum logic {
    REQ_POSE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [AXIS_W-1:0] {
    SLOT_ROLL     = 2'd0,
    SLOT_PITCH    = 2'd1,
    SLOT_THROTTLE = 2'd2
  } slot_t;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [GAIN_W-1:0] gain_word_t;

  typedef struct packed {
    err_t ex;
    err_t ey;
    err_t ez;
  } err_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic axis_t slot_axis(slot_t slot);
    axis_t ax;
    case (slot)
      SLOT_ROLL:  ax = AXIS_Y;
      SLOT_PITCH: ax = AXIS_X;
      default:    ax = AXIS_Z;
    endcase
    return ax;
  endfunction

endpackage

### rtl/three_axis_position_pid.sv
// Top level: a tick result reaches the result register after the tick passes the queue and
// the back part steps the three axes one by one through the shared multiplier, taking no new tick
// until the result is loaded; pose samples are taken one per cycle while the queue has room.
// Reset (rst, synchronous) restores setpoints 26/0/4864, zeroes gains, held positions,
// last errors and integrals, and empties the queue and the result register.
// Depends on tppid_pkg, tppid_front, tppid_fifo, tppid_back.
module three_axis_position_pid import tppid_pkg::*; #(
  parameter int POS_WIDTH      = POS_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic                    req_type,
  input  logic signed [RAW_W-1:0] raw_x,
  input  logic signed [RAW_W-1:0] raw_y,
  input  logic signed [RAW_W-1:0] raw_z,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic [CMD_W-1:0]        roll_cmd,
  output logic [CMD_W-1:0]        pitch_cmd,
  output logic [CMD_W-1:0]        throttle_cmd,
  output logic signed [ERR_W-1:0] roll_err,
  output logic signed [ERR_W-1:0] pitch_err,
  output logic signed [ERR_W-1:0] throttle_err,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [GAIN_W-1:0]       cfg_data
);

  logic signed [SP_W-1:0]          setpoint_x, setpoint_y, setpoint_z;
  logic [NUM_AXES-1:0][GAIN_W-1:0] gains;
  queue_status_t                   qstat;
  logic                            push, pop;
  err_set_t                        push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_x <= SETPOINT_X_RST;
      setpoint_y <= SETPOINT_Y_RST;
      setpoint_z <= SETPOINT_Z_RST;
      gains      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_SETPOINT_X:     setpoint_x <= cfg_data[SP_W-1:0];
        REG_SETPOINT_Y:     setpoint_y <= cfg_data[SP_W-1:0];
        REG_SETPOINT_Z:     setpoint_z <= cfg_data[SP_W-1:0];
        REG_GAINS_ROLL:     gains[SLOT_ROLL] <= cfg_data;
        REG_GAINS_PITCH:    gains[SLOT_PITCH] <= cfg_data;
        REG_GAINS_THROTTLE: gains[SLOT_THROTTLE] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tppid_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .raw_x      (raw_x),
    .raw_y      (raw_y),
    .raw_z      (raw_z),
    .setpoint_x (setpoint_x),
    .setpoint_y (setpoint_y),
    .setpoint_z (setpoint_z),
    .qstat      (qstat),
    .push       (push),
    .push_data  (push_data)
  );

  tppid_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  tppid_back #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .gains        (gains),
    .qstat        (qstat),
    .pop_data     (pop_data),
    .pop          (pop),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .roll_cmd     (roll_cmd),
    .pitch_cmd    (pitch_cmd),
    .throttle_cmd (throttle_cmd),
    .roll_err     (roll_err),
    .pitch_err    (pitch_err),
    .throttle_err (throttle_err)
  );

endmodule

### rtl/tppid_front.sv
// Front part: accepts request transactions, stores pose samples and
// snapshots the three axis errors of each control tick into the queue.
// Depends on tppid_pkg.
module tppid_front import tppid_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   req_type,
  input  logic signed [RAW_W-1:0] raw_x,
  input  logic signed [RAW_W-1:0] raw_y,
  input  logic signed [RAW_W-1:0] raw_z,
  input  logic signed [SP_W-1:0]  setpoint_x,
  input  logic signed [SP_W-1:0]  setpoint_y,
  input  logic signed [SP_W-1:0]  setpoint_z,
  input  queue_status_t          qstat,
  output logic                   push,
  output err_set_t               push_data
);

  localparam int WW = POS_WIDTH + 18;

  localparam logic signed [WW-1:0] POS_HI = (WW'(1) <<< (POS_WIDTH - 1)) - WW'(1);
  localparam logic signed [WW-1:0] POS_LO = -POS_HI - WW'(1);
  localparam logic signed [WW-1:0] ERR_HI = (WW'(1) <<< (ERR_W - 1)) - WW'(1);
  localparam logic signed [WW-1:0] ERR_LO = -ERR_HI - WW'(1);

  logic signed [POS_WIDTH-1:0] pos_x, pos_y, pos_z;
  logic                        accept;
  logic signed [17:0]          map_x, map_y, map_z;

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(logic signed [17:0] v);
    logic signed [WW-1:0] w;
    logic signed [WW-1:0] r;
    w = WW'(v);
    if (w > POS_HI) begin
      r = POS_HI;
    end else if (w < POS_LO) begin
      r = POS_LO;
    end else begin
      r = w;
    end
    return r[POS_WIDTH-1:0];
  endfunction

  function automatic err_t sat_err(logic signed [SP_W-1:0] sp,
                                   logic signed [POS_WIDTH-1:0] pos);
    logic signed [WW-1:0] d;
    logic signed [WW-1:0] r;
    d = WW'(sp) - WW'(pos);
    if (d > ERR_HI) begin
      r = ERR_HI;
    end else if (d < ERR_LO) begin
      r = ERR_LO;
    end else begin
      r = d;
    end
    return r[ERR_W-1:0];
  endfunction

  assign req_stall = qstat.full;
  assign accept    = req_valid && !qstat.full;
  assign push      = accept && (req_type_t'(req_type) == REQ_TICK);

  assign map_x = -(18'(raw_x));
  assign map_y = -(18'(raw_y));
  assign map_z = 18'(Z_OFFSET) - 18'(raw_z);

  always_comb begin
    push_data.ex = sat_err(setpoint_x, pos_x);
    push_data.ey = sat_err(setpoint_y, pos_y);
    push_data.ez = sat_err(setpoint_z, pos_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept && (req_type_t'(req_type) == REQ_POSE)) begin
      pos_x <= sat_pos(map_x);
      pos_y <= sat_pos(map_y);
      pos_z <= sat_pos(map_z);
    end
  end

endmodule

### rtl/tppid_fifo.sv
// Short queue of error snapshots between the front and back parts.
// Register based, QUEUE_DEPTH entries. Depends on tppid_pkg.
module tppid_fifo import tppid_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  err_set_t      push_data,
  input  logic          pop,
  output err_set_t      pop_data,
  output queue_status_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  err_set_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_data    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/tppid_mul.sv
// Shared signed multiplier with a registered product.
// Generic widths; no package dependency.
module tppid_mul #(
  parameter int A_W = 29,
  parameter int B_W = 18
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
  end

endmodule

### rtl/tppid_back.sv
// Back part: sequences the three axes of a tick through one shared multiplier,
// keeps the last errors and integrals, and holds the result register.
// Depends on tppid_pkg and tppid_mul.
module tppid_back import tppid_pkg::*; #(
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [NUM_AXES-1:0][GAIN_W-1:0]     gains,
  input  queue_status_t                       qstat,
  input  err_set_t                            pop_data,
  output logic                                pop,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [CMD_W-1:0]                    roll_cmd,
  output logic [CMD_W-1:0]                    pitch_cmd,
  output logic [CMD_W-1:0]                    throttle_cmd,
  output logic signed [ERR_W-1:0]             roll_err,
  output logic signed [ERR_W-1:0]             pitch_err,
  output logic signed [ERR_W-1:0]             throttle_err
);

  localparam int W    = INTEGRAL_WIDTH;
  localparam int HALF = (W + 1) / 2;
  localparam int HI_W = W - HALF;
  localparam int BW   = (HALF + 1 > 18) ? HALF + 1 : 18;
  localparam int PW   = MUL_A_W + BW;
  localparam int IMW  = W + 17;
  localparam int CW   = IMW + ITERM_W;
  localparam int IW2  = W + 18;

  localparam logic signed [IW2-1:0] INT_HI = (IW2'(1) <<< (W - 1)) - IW2'(1);
  localparam logic signed [IW2-1:0] INT_LO = -INT_HI - IW2'(1);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_KP    = 12'b000000000010,
    ST_PE    = 12'b000000000100,
    ST_KD    = 12'b000000001000,
    ST_DE    = 12'b000000010000,
    ST_ILO   = 12'b000000100000,
    ST_IHI   = 12'b000001000000,
    ST_IADD  = 12'b000010000000,
    ST_ITERM = 12'b000100000000,
    ST_RECIP = 12'b001000000000,
    ST_CMD   = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_t;

  state_t                   state;
  slot_t                    slot;
  err_set_t                 err_q;
  logic signed [SUM_W-1:0]  acc;
  logic [IMW-1:0]           magacc;
  logic [W-1:0]             imag;
  logic                     neg, big;
  logic [CMD_W-1:0]         cmd_hold [NUM_AXES];
  err_t                     last_err [NUM_AXES];
  logic signed [W-1:0]      integ    [NUM_AXES];

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [BW-1:0]      mul_b;
  logic signed [PW-1:0]      prod;

  axis_t                    ax;
  err_t                     e_cur, last_cur;
  logic signed [W-1:0]      integ_cur;
  gain_word_t               gain_cur;
  logic [COEF_W-1:0]        kp, ki, kd;
  logic signed [ERR_W:0]    diff;
  logic signed [W:0]        integ_ext;
  logic [W-1:0]             imag_next;
  logic [HALF-1:0]          imag_lo;
  logic [HI_W-1:0]          imag_hi;
  logic                     over;
  logic [ITERM_W-1:0]       iterm_mag;
  logic [SUM_W-1:0]         acc_mag;
  logic                     big_next;
  logic [SCALED_W-1:0]      scaled;
  logic [QUOT_W-1:0]        quot;
  logic signed [CMD_W:0]    quot_s, cmd_sum;
  logic [CMD_W-1:0]         cmd_lo, cmd_val;
  logic signed [IW2-1:0]    isum;
  logic signed [W-1:0]      integ_new;
  logic                     out_free;

  tppid_mul #(
    .A_W (MUL_A_W),
    .B_W (BW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign ax        = slot_axis(slot);
  assign gain_cur  = gains[slot];
  assign kp        = gain_cur[COEF_W-1:0];
  assign ki        = gain_cur[2*COEF_W-1:COEF_W];
  assign kd        = gain_cur[3*COEF_W-1:2*COEF_W];
  assign last_cur  = last_err[ax];
  assign integ_cur = integ[ax];
  assign pop       = (state == ST_IDLE) && !qstat.empty;
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    case (ax)
      AXIS_X:  e_cur = err_q.ex;
      AXIS_Y:  e_cur = err_q.ey;
      default: e_cur = err_q.ez;
    endcase
  end

  assign diff      = (ERR_W + 1)'(e_cur) - (ERR_W + 1)'(last_cur);
  assign integ_ext = (W + 1)'(integ_cur);
  assign imag_next = integ_cur[W-1] ? W'(-integ_ext) : W'(integ_ext);
  assign imag_lo   = imag[HALF-1:0];
  assign imag_hi   = imag[W-1:HALF];

  assign over      = CW'(magacc) > CW'(KI_LIMIT_PRE);
  assign iterm_mag = over ? ITERM_W'(KI_LIMIT)
                          : ITERM_W'({magacc, 3'b000}) + ITERM_W'(magacc);

  assign acc_mag  = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
  assign big_next = acc_mag >= SUM_W'(SAT_LIMIT);
  assign scaled   = acc_mag[DIV_SHIFT+SCALED_W-1:DIV_SHIFT];

  assign quot    = prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  assign quot_s  = neg ? -((CMD_W + 1)'(quot)) : (CMD_W + 1)'(quot);
  assign cmd_sum = (CMD_W + 1)'(CMD_MID) + quot_s;
  assign cmd_lo  = (slot == SLOT_THROTTLE) ? CMD_W'(CMD_MIN_THR) : CMD_W'(CMD_MIN_RP);

  always_comb begin
    if (big) begin
      cmd_val = neg ? cmd_lo : CMD_W'(CMD_MAX);
    end else if (cmd_sum < (CMD_W + 1)'(cmd_lo)) begin
      cmd_val = cmd_lo;
    end else begin
      cmd_val = cmd_sum[CMD_W-1:0];
    end
  end

  assign isum = IW2'(integ_cur) + IW2'(e_cur);

  always_comb begin
    if (isum > INT_HI) begin
      integ_new = INT_HI[W-1:0];
    end else if (isum < INT_LO) begin
      integ_new = INT_LO[W-1:0];
    end else begin
      integ_new = isum[W-1:0];
    end
  end

  always_comb begin
    case (state)
      ST_KP: begin
        mul_a = MUL_A_W'(kp);
        mul_b = BW'(KP_SCALE);
      end
      ST_PE: begin
        mul_a = MUL_A_W'(prod);
        mul_b = BW'(e_cur);
      end
      ST_KD: begin
        mul_a = MUL_A_W'(kd);
        mul_b = BW'(KD_SCALE);
      end
      ST_DE: begin
        mul_a = MUL_A_W'(prod);
        mul_b = BW'(diff);
      end
      ST_ILO: begin
        mul_a = MUL_A_W'(ki);
        mul_b = BW'(imag_lo);
      end
      ST_IHI: begin
        mul_a = MUL_A_W'(ki);
        mul_b = BW'(imag_hi);
      end
      ST_RECIP: begin
        mul_a = MUL_A_W'(RECIP);
        mul_b = BW'(scaled);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= SLOT_ROLL;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        last_err[i] <= '0;
        integ[i]    <= '0;
      end
    end else begin
      if (rsp_valid && !rsp_stall && (state != ST_OUT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!qstat.empty) begin
            slot  <= SLOT_ROLL;
            state <= ST_KP;
          end
        end
        ST_KP:    state <= ST_PE;
        ST_PE:    state <= ST_KD;
        ST_KD:    state <= ST_DE;
        ST_DE:    state <= ST_ILO;
        ST_ILO:   state <= ST_IHI;
        ST_IHI:   state <= ST_IADD;
        ST_IADD:  state <= ST_ITERM;
        ST_ITERM: state <= ST_RECIP;
        ST_RECIP: state <= ST_CMD;
        ST_CMD: begin
          last_err[ax] <= e_cur;
          integ[ax]    <= integ_new;
          case (slot)
            SLOT_ROLL:  slot <= SLOT_PITCH;
            SLOT_PITCH: slot <= SLOT_THROTTLE;
            default:    slot <= SLOT_ROLL;
          endcase
          state <= (slot == SLOT_THROTTLE) ? ST_OUT : ST_KP;
        end
        ST_OUT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        err_q <= pop_data;
      end
      ST_KP: begin
        imag <= imag_next;
      end
      ST_KD: begin
        acc <= SUM_W'(prod);
      end
      ST_ILO: begin
        acc <= acc + SUM_W'(prod);
      end
      ST_IHI: begin
        magacc <= IMW'(prod);
      end
      ST_IADD: begin
        magacc <= magacc + (IMW'(prod) << HALF);
      end
      ST_ITERM: begin
        acc <= integ_cur[W-1] ? acc - SUM_W'(iterm_mag) : acc + SUM_W'(iterm_mag);
      end
      ST_RECIP: begin
        neg <= acc[SUM_W-1];
        big <= big_next;
      end
      ST_CMD: begin
        cmd_hold[slot] <= cmd_val;
      end
      ST_OUT: begin
        if (out_free) begin
          roll_cmd     <= cmd_hold[SLOT_ROLL];
          pitch_cmd    <= cmd_hold[SLOT_PITCH];
          throttle_cmd <= cmd_hold[SLOT_THROTTLE];
          roll_err     <= err_q.ey;
          pitch_err    <= err_q.ex;
          throttle_err <= err_q.ez;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/tppid_checker.sv
// Port-level checker for the three-axis position PID controller, bound to the top level.
// Depends on tppid_pkg.
module tppid_checker import tppid_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_stall,
  input logic                    req_type,
  input logic signed [RAW_W-1:0] raw_x,
  input logic signed [RAW_W-1:0] raw_y,
  input logic signed [RAW_W-1:0] raw_z,
  input logic                    rsp_valid,
  input logic                    rsp_stall,
  input logic [CMD_W-1:0]        roll_cmd,
  input logic [CMD_W-1:0]        pitch_cmd,
  input logic [CMD_W-1:0]        throttle_cmd,
  input logic signed [ERR_W-1:0] roll_err,
  input logic signed [ERR_W-1:0] pitch_err,
  input logic signed [ERR_W-1:0] throttle_err
);

  a_no_result_after_reset: assert property (
    @(posedge clk) $past(rst) |-> !rsp_valid
  ) else $error("result valid right after reset");

  a_rp_range: assert property (
    @(posedge clk) disable iff (rst)
    rsp_valid |-> (roll_cmd >= CMD_W'(CMD_MIN_RP)) && (roll_cmd <= CMD_W'(CMD_MAX)) &&
                  (pitch_cmd >= CMD_W'(CMD_MIN_RP)) && (pitch_cmd <= CMD_W'(CMD_MAX))
  ) else $error("roll or pitch command out of range");

  a_thr_range: assert property (
    @(posedge clk) disable iff (rst)
    rsp_valid |-> (throttle_cmd >= CMD_W'(CMD_MIN_THR)) &&
                  (throttle_cmd <= CMD_W'(CMD_MAX))
  ) else $error("throttle command out of range");

  a_rsp_hold: assert property (
    @(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(roll_cmd) && $stable(pitch_cmd) &&
                               $stable(throttle_cmd) && $stable(roll_err) &&
                               $stable(pitch_err) && $stable(throttle_err)
  ) else $error("stalled result transaction changed");

  a_req_hold: assert property (
    @(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req_type) && $stable(raw_x) &&
                               $stable(raw_y) && $stable(raw_z)
  ) else $error("stalled request transaction changed");

endmodule

bind three_axis_position_pid tppid_checker u_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for three_axis_position_pid: drives pose and tick transactions and register writes,
// and checks every RC command frame against a cycle-free PID predictor held in a scoreboard.
// Depends on tppid_pkg and the three_axis_position_pid RTL.
module tb;
  import tppid_pkg::*;

  localparam int CYCLE_LIMIT   = 3000000;
  localparam int TICK_LATENCY  = 32;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 180;
  localparam int WINDUP_TICKS  = 80;
  localparam int UNWIND_TICKS  = 80;
  localparam int MAX_REPORTS   = 10;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int     HELD_W      = 16;
  localparam int     SUM_BITS    = 32;
  localparam longint Z_BIAS      = 8192;
  localparam longint P_MUL       = 150;
  localparam longint D_MUL       = 2500;
  localparam longint I_MUL       = 9;
  localparam longint OUT_DIV     = 38400;
  localparam longint I_CAP       = longint'(1) << 60;
  localparam longint RC_CENTER   = 1500;
  localparam longint RC_TOP      = 2000;
  localparam longint RC_FLOOR    = 1000;
  localparam longint THR_FLOOR   = 1500;

  typedef struct packed {
    logic [CMD_W-1:0] roll;
    logic [CMD_W-1:0] pitch;
    logic [CMD_W-1:0] throttle;
    err_t             roll_e;
    err_t             pitch_e;
    err_t             throttle_e;
  } rc_frame_t;

  class rc_command_scoreboard;
    longint           setpoint[3];
    logic [GAIN_W-1:0] gains[3];
    longint           held[3];
    longint           last_err[3];
    longint           err_sum[3];
    rc_frame_t        expected_frames[$];
    int               mismatch_count;
    int               frames_checked;

    function new();
      setpoint[AXIS_X] = 26;
      setpoint[AXIS_Y] = 0;
      setpoint[AXIS_Z] = 4864;
      for (int i = 0; i < 3; i++) begin
        gains[i]    = '0;
        held[i]     = 0;
        last_err[i] = 0;
        err_sum[i]  = 0;
      end
      mismatch_count = 0;
      frames_checked = 0;
    endfunction

    function longint saturate(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function longint clamp_rc(longint v, longint lo);
      if (v > RC_TOP) v = RC_TOP;
      if (v < lo) v = lo;
      return v;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      logic signed [SP_W-1:0] sp;
      sp = data[SP_W-1:0];
      case (idx)
        REG_SETPOINT_X:     setpoint[AXIS_X] = sp;
        REG_SETPOINT_Y:     setpoint[AXIS_Y] = sp;
        REG_SETPOINT_Z:     setpoint[AXIS_Z] = sp;
        REG_GAINS_ROLL:     gains[SLOT_ROLL] = data;
        REG_GAINS_PITCH:    gains[SLOT_PITCH] = data;
        REG_GAINS_THROTTLE: gains[SLOT_THROTTLE] = data;
        default: ;
      endcase
    endfunction

    function longint axis_cmd(axis_t ax, logic [GAIN_W-1:0] g, longint e);
      longint kp;
      longint ki;
      longint kd;
      longint integ;
      longint mag;
      longint iterm;
      longint total;
      kp = g[15:0];
      ki = g[31:16];
      kd = g[47:32];
      integ = err_sum[ax];
      mag = (integ < 0 ? -integ : integ) * ki;
      if (mag > I_CAP / I_MUL) mag = I_CAP;
      else mag = mag * I_MUL;
      iterm = integ < 0 ? -mag : mag;
      total = P_MUL * kp * e + D_MUL * kd * (e - last_err[ax]) + iterm;
      return RC_CENTER + total / OUT_DIV;
    endfunction

    function void note_request(req_type_t kind, logic signed [RAW_W-1:0] rx,
                               logic signed [RAW_W-1:0] ry, logic signed [RAW_W-1:0] rz);
      longint    e[3];
      longint    roll_v;
      longint    pitch_v;
      longint    thr_v;
      rc_frame_t f;
      if (kind == REQ_POSE) begin
        held[AXIS_X] = saturate(-longint'(rx), HELD_W);
        held[AXIS_Y] = saturate(-longint'(ry), HELD_W);
        held[AXIS_Z] = saturate(Z_BIAS - longint'(rz), HELD_W);
        return;
      end
      for (int i = 0; i < 3; i++) e[i] = saturate(setpoint[i] - held[i], ERR_W);
      roll_v  = axis_cmd(AXIS_Y, gains[SLOT_ROLL], e[AXIS_Y]);
      pitch_v = axis_cmd(AXIS_X, gains[SLOT_PITCH], e[AXIS_X]);
      thr_v   = axis_cmd(AXIS_Z, gains[SLOT_THROTTLE], e[AXIS_Z]);
      for (int i = 0; i < 3; i++) begin
        last_err[i] = e[i];
        err_sum[i]  = saturate(err_sum[i] + e[i], SUM_BITS);
      end
      f.roll       = CMD_W'(clamp_rc(roll_v, RC_FLOOR));
      f.pitch      = CMD_W'(clamp_rc(pitch_v, RC_FLOOR));
      f.throttle   = CMD_W'(clamp_rc(thr_v, THR_FLOOR));
      f.roll_e     = ERR_W'(e[AXIS_Y]);
      f.pitch_e    = ERR_W'(e[AXIS_X]);
      f.throttle_e = ERR_W'(e[AXIS_Z]);
      expected_frames.push_back(f);
    endfunction

    function void check_command(logic [CMD_W-1:0] r, logic [CMD_W-1:0] p, logic [CMD_W-1:0] t,
                                err_t re, err_t pe, err_t te);
      rc_frame_t got;
      rc_frame_t want;
      got.roll       = r;
      got.pitch      = p;
      got.throttle   = t;
      got.roll_e     = re;
      got.pitch_e    = pe;
      got.throttle_e = te;
      if (expected_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected command frame: roll %0d pitch %0d thr %0d errs %0d %0d %0d",
                   r, p, t, re, pe, te);
        return;
      end
      want = expected_frames.pop_front();
      frames_checked++;
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("frame %0d mismatch: expected roll %0d pitch %0d thr %0d errs %0d %0d %0d",
                   frames_checked, want.roll, want.pitch, want.throttle,
                   want.roll_e, want.pitch_e, want.throttle_e);
          $display("  actual roll %0d pitch %0d thr %0d errs %0d %0d %0d",
                   r, p, t, re, pe, te);
        end
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    req_valid;
  logic                    req_stall;
  logic                    req_type;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W-1:0] raw_z;
  logic                    rsp_valid;
  logic                    rsp_stall;
  logic [CMD_W-1:0]        roll_cmd;
  logic [CMD_W-1:0]        pitch_cmd;
  logic [CMD_W-1:0]        throttle_cmd;
  err_t                    roll_err;
  err_t                    pitch_err;
  err_t                    throttle_err;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index;
  logic [GAIN_W-1:0]       cfg_data;

  rc_command_scoreboard board;
  int cycle_count;
  int rsp_stall_pct;
  int stall_run;
  logic stall_level;
  int pose_count;
  int tick_count;
  int reg_writes;
  int settings_count;

  three_axis_position_pid dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .raw_x        (raw_x),
    .raw_y        (raw_y),
    .raw_z        (raw_z),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .roll_cmd     (roll_cmd),
    .pitch_cmd    (pitch_cmd),
    .throttle_cmd (throttle_cmd),
    .roll_err     (roll_err),
    .pitch_err    (pitch_err),
    .throttle_err (throttle_err),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_level = ($urandom_range(99) < rsp_stall_pct);
      stall_run = $urandom_range(1, 12);
    end else begin
      stall_run--;
    end
    rsp_stall <= stall_level;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      board.check_command(roll_cmd, pitch_cmd, throttle_cmd, roll_err, pitch_err, throttle_err);
  end

  task automatic send_item(req_type_t kind, logic signed [RAW_W-1:0] rx,
                           logic signed [RAW_W-1:0] ry, logic signed [RAW_W-1:0] rz);
    @(negedge clk);
    req_valid <= 1'b1;
    req_type  <= kind;
    raw_x     <= rx;
    raw_y     <= ry;
    raw_z     <= rz;
    do @(posedge clk); while (req_stall);
    board.note_request(kind, rx, ry, rz);
    if (kind == REQ_TICK) tick_count++;
    else pose_count++;
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until every expected frame is back, then let the design go idle
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (2 * TICK_LATENCY) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    return COEF_W'($urandom_range(0, 65535) >> $urandom_range(0, 16));
  endfunction

  function automatic logic [GAIN_W-1:0] rand_setpoint_word();
    logic [GAIN_W-1:0] w;
    w = GAIN_W'({$urandom, $urandom});
    if ($urandom_range(1)) w[SP_W-1:0] = SP_W'($urandom_range(0, 8191)) - SP_W'(4096);
    return w;
  endfunction

  task automatic random_phase(int n, int tick_pct, int near_pct, int gap_max);
    int sent;
    int burst;
    int span;
    int d;
    req_type_t kind;
    logic signed [RAW_W-1:0] rx;
    logic signed [RAW_W-1:0] ry;
    logic signed [RAW_W-1:0] rz;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < n; k++) begin
        kind = ($urandom_range(99) < tick_pct) ? REQ_TICK : REQ_POSE;
        rx = RAW_W'($urandom);
        ry = RAW_W'($urandom);
        rz = RAW_W'($urandom);
        if (kind == REQ_POSE && $urandom_range(99) < near_pct) begin
          span = $urandom_range(16, 4096);
          d = $urandom_range(0, 2 * span);
          rx = RAW_W'(-board.setpoint[AXIS_X] + d - span);
          d = $urandom_range(0, 2 * span);
          ry = RAW_W'(-board.setpoint[AXIS_Y] + d - span);
          d = $urandom_range(0, 2 * span);
          rz = RAW_W'(Z_BIAS - board.setpoint[AXIS_Z] + d - span);
        end
        send_item(kind, rx, ry, rz);
        sent++;
      end
      if (gap_max > 0) hold_off($urandom_range(0, gap_max));
    end
  endtask

  initial begin
    int gap_max;
    board = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = REQ_POSE;
    raw_x = '0;
    raw_y = '0;
    raw_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rsp_stall_pct = 30;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers, tick before any pose, then mapped position extremes
    settings_count = 1;
    send_item(REQ_TICK, 16'sh1234, 16'sh5678, 16'sh1ABC);
    send_item(REQ_POSE, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(REQ_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
    send_item(REQ_POSE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_item(REQ_TICK, 16'shFFFF, 16'shFFFF, 16'shFFFF);
    drain();

    // extreme setpoints with junk in upper bits, full-scale gains, spare indexes
    write_reg(REG_SETPOINT_X, 48'hFFFF_A5A5_7FFF);
    write_reg(REG_SETPOINT_Y, 48'h5A5A_0000_8000);
    write_reg(REG_SETPOINT_Z, 48'hFFFF_FFFF_0000);
    write_reg(REG_GAINS_ROLL, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_GAINS_PITCH, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_GAINS_THROTTLE, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_SPARE_LO, 48'h0000_0000_0000);
    write_reg(REG_SPARE_HI, 48'hFFFF_FFFF_FFFF);
    settings_count++;
    send_item(REQ_POSE, 16'sh0000, 16'sh0000, 16'sh0000);
    send_item(REQ_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
    send_item(REQ_TICK, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_item(REQ_POSE, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_item(REQ_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
    send_item(REQ_POSE, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_item(REQ_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
    send_item(REQ_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_SETPOINT_X, rand_setpoint_word());
      write_reg(REG_SETPOINT_Y, rand_setpoint_word());
      write_reg(REG_SETPOINT_Z, rand_setpoint_word());
      write_reg(REG_GAINS_ROLL, {rand_coef(), rand_coef(), rand_coef()});
      write_reg(REG_GAINS_PITCH, {rand_coef(), rand_coef(), rand_coef()});
      write_reg(REG_GAINS_THROTTLE, {rand_coef(), rand_coef(), rand_coef()});
      if ($urandom_range(1)) write_reg(REG_SPARE_LO, GAIN_W'({$urandom, $urandom}));
      if ($urandom_range(1)) write_reg(REG_SPARE_HI, GAIN_W'({$urandom, $urandom}));
      settings_count++;
      rsp_stall_pct = (p % 3 == 0) ? 0 : $urandom_range(20, 80);
      gap_max = (p == 1) ? 0 : $urandom_range(2, 20);
      random_phase(PHASE_ITEMS, $urandom_range(25, 75), 75, gap_max);
      drain();
    end

    // wind every integrator deep negative, then unwind it
    rsp_stall_pct = 0;
    write_reg(REG_SETPOINT_X, 48'h0000_0000_8000);
    write_reg(REG_SETPOINT_Y, 48'h0000_0000_8000);
    write_reg(REG_SETPOINT_Z, 48'h0000_0000_8000);
    write_reg(REG_GAINS_ROLL, 48'h0000_0001_0000);
    write_reg(REG_GAINS_PITCH, 48'h0000_0001_0000);
    write_reg(REG_GAINS_THROTTLE, 48'h0000_0001_0000);
    settings_count++;
    send_item(REQ_POSE, 16'sh8000, 16'sh8000, 16'sh8000);
    for (int k = 0; k < WINDUP_TICKS; k++) begin
      send_item(REQ_TICK, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
    end
    drain();
    write_reg(REG_SETPOINT_X, 48'h0000_0000_7FFF);
    write_reg(REG_SETPOINT_Y, 48'h0000_0000_7FFF);
    write_reg(REG_SETPOINT_Z, 48'h0000_0000_7FFF);
    settings_count++;
    rsp_stall_pct = 40;
    send_item(REQ_POSE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    for (int k = 0; k < UNWIND_TICKS; k++) begin
      send_item(REQ_TICK, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
    end
    drain();

    $display("covered %0d pose samples and %0d control ticks under %0d register settings",
             pose_count, tick_count, settings_count);
    $display("%0d register writes, %0d command frames checked, %0d mismatches",
             reg_writes, board.frames_checked, board.mismatch_count);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
